FILE: sv/wsta_pkg.sv
// Shared widths, codes and the link word passed along the server cell chain.
`default_nettype none

package wsta_pkg;

    localparam int TIME_W          = 32;
    localparam int WEIGHT_W        = 16;
    localparam int DUR_W           = 20;
    localparam int SLOT_W          = 4;
    localparam int CFG_W           = 5;
    // Wide enough for a cell index at the largest supported server count
    localparam int IDX_W           = 10;
    localparam int MAX_SERVERS_DEF = 16;

    localparam logic [CFG_W-1:0]  CFG_RESET = CFG_W'(16);
    localparam logic [TIME_W-1:0] TIME_MAX  = {TIME_W{1'b1}};

    // Item function codes
    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_TASK = 1'b1;

    // Which pass the token is making along the chain
    typedef enum logic {
        PH_MIN,
        PH_PICK
    } t_phase;

    // Running result carried from cell to cell
    typedef struct packed {
        logic                valid;
        logic [TIME_W-1:0]   min_free;
        logic                found;
        logic [IDX_W-1:0]    best_idx;
        logic [WEIGHT_W-1:0] best_weight;
    } t_link;

endpackage

`default_nettype wire

FILE: sv/wsta_cell.sv
// One server cell: holds weight and free time, updates the passing link word.
`default_nettype none

module wsta_cell
    import wsta_pkg::*;
#(
    parameter int CELL_IDX = 0
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_active,
    input  wire t_phase              i_phase,
    input  wire logic [TIME_W-1:0]   i_time,
    input  wire logic                i_weight_we,
    input  wire logic [WEIGHT_W-1:0] i_weight,
    input  wire logic                i_free_we,
    input  wire logic [TIME_W-1:0]   i_free,
    input  wire t_link               i_link,
    output t_link                    o_link
);

    logic [WEIGHT_W-1:0] r_weight;
    logic [TIME_W-1:0]   r_free;
    t_link               r_link;
    t_link               n_link;

    // Fold this server into the running minimum or the running best choice
    always_comb begin
        n_link = i_link;
        if (i_link.valid && i_active) begin
            case (i_phase)
                PH_MIN: begin
                    if (r_free < i_link.min_free) begin
                        n_link.min_free = r_free;
                    end
                end
                PH_PICK: begin
                    if ((r_free <= i_time) &&
                        (!i_link.found || (r_weight < i_link.best_weight))) begin
                        n_link.found       = 1'b1;
                        n_link.best_idx    = IDX_W'(CELL_IDX);
                        n_link.best_weight = r_weight;
                    end
                end
                default: begin
                    n_link = i_link;
                end
            endcase
        end
    end

    // Hold server state, advance the link word one cell per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_weight     <= '0;
            r_free       <= '0;
            r_link.valid <= 1'b0;
        end else begin
            if (i_weight_we) begin
                r_weight <= i_weight;
            end
            if (i_free_we) begin
                r_free <= i_free;
            end
            r_link.valid <= n_link.valid;
        end
        r_link.min_free    <= n_link.min_free;
        r_link.found       <= n_link.found;
        r_link.best_idx    <= n_link.best_idx;
        r_link.best_weight <= n_link.best_weight;
    end

    assign o_link = r_link;

endmodule

`default_nettype wire

FILE: sv/weighted_server_task_assigner.sv
// Top level: command port, server cell chain and the two-pass task sequencer.
//
//  channel  | signals                                          | handshake
//  ---------+--------------------------------------------------+--------------------------
//  command  | i_func, i_server_slot, i_weight, i_duration      | start & !busy
//  result   | o_assigned_server, o_start_second                | o_done, one cycle, no stall
//  config   | i_cfg_data (active_servers)                      | i_cfg_valid & o_cfg_ready
//
// A weight load does not make the block busy. A task makes the token walk
// the cell chain once to find the earliest free time, then once more to pick
// the lightest free server, one cell a cycle.
// The result word is shown on o_done in the cycle busy falls.
// Reset is synchronous, active low; all servers are free with weight zero.
// Config is always ready and must be written only while idle.
`default_nettype none

module weighted_server_task_assigner
    import wsta_pkg::*;
#(
    parameter int MAX_SERVERS = MAX_SERVERS_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire logic                i_func,
    input  wire logic [SLOT_W-1:0]   i_server_slot,
    input  wire logic [WEIGHT_W-1:0] i_weight,
    input  wire logic [DUR_W-1:0]    i_duration,
    output logic                     o_done,
    output logic [SLOT_W-1:0]        o_assigned_server,
    output logic [TIME_W-1:0]        o_start_second,
    input  wire logic                i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire logic [CFG_W-1:0]    i_cfg_data
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MIN,
        ST_PICK
    } t_state;

    t_state              r_state;
    logic                r_inject;
    logic [CFG_W-1:0]    r_active;
    logic [TIME_W-1:0]   r_time;
    logic [TIME_W-1:0]   r_arrival;
    logic [TIME_W-1:0]   r_prev_start;
    logic [DUR_W-1:0]    r_duration;
    logic                r_done;
    logic [SLOT_W-1:0]   r_assigned;
    logic [TIME_W-1:0]   r_start_out;

    t_link               w_link [MAX_SERVERS+1];
    t_link               w_tail;
    t_phase              w_phase;
    logic                w_accept;
    logic                w_load;
    logic [TIME_W-1:0]   w_t0;
    logic [TIME_W:0]     w_finish_sum;
    logic [TIME_W-1:0]   w_finish;
    logic [TIME_W:0]     w_arrival_sum;
    logic [TIME_W-1:0]   w_arrival_next;

    assign w_accept = start && !busy;
    assign w_load   = w_accept && (i_func == FUNC_LOAD);
    assign w_phase  = (r_state == ST_PICK) ? PH_PICK : PH_MIN;
    assign w_tail   = w_link[MAX_SERVERS];

    // Start of a task: later of arrival and previous start
    assign w_t0 = (r_arrival > r_prev_start) ? r_arrival : r_prev_start;

    // Saturating finish time and next arrival second
    assign w_finish_sum   = {1'b0, r_time} + (TIME_W+1)'(r_duration);
    assign w_finish       = w_finish_sum[TIME_W] ? TIME_MAX : w_finish_sum[TIME_W-1:0];
    assign w_arrival_sum  = {1'b0, r_arrival} + (TIME_W+1)'(1);
    assign w_arrival_next = w_arrival_sum[TIME_W] ? TIME_MAX
                                                  : w_arrival_sum[TIME_W-1:0];

    // Token word entering the head of the chain
    always_comb begin
        w_link[0].valid       = r_inject;
        w_link[0].min_free    = TIME_MAX;
        w_link[0].found       = 1'b0;
        w_link[0].best_idx    = '0;
        w_link[0].best_weight = '0;
    end

    // Row of server cells
    for (genvar i = 0; i < MAX_SERVERS; i++) begin : g_cell
        logic w_active;
        logic w_weight_we;
        logic w_free_we;

        // Slot zero is always in use; counts above the row are clamped by its length
        assign w_active    = (i == 0) || (32'(i) < 32'(r_active));
        assign w_weight_we = w_load && (32'(i_server_slot) == 32'(i));
        assign w_free_we   = (r_state == ST_PICK) && w_tail.valid &&
                             (32'(w_tail.best_idx) == 32'(i));

        wsta_cell #(
            .CELL_IDX (i)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_active    (w_active),
            .i_phase     (w_phase),
            .i_time      (r_time),
            .i_weight_we (w_weight_we),
            .i_weight    (i_weight),
            .i_free_we   (w_free_we),
            .i_free      (w_finish),
            .i_link      (w_link[i]),
            .o_link      (w_link[i+1])
        );
    end

    // Sequence the two passes and register the result word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_inject     <= 1'b0;
            r_active     <= CFG_RESET;
            r_arrival    <= '0;
            r_prev_start <= '0;
            r_done       <= 1'b0;
        end else begin
            r_inject <= 1'b0;
            r_done   <= 1'b0;
            if (i_cfg_valid) begin
                r_active <= i_cfg_data;
            end
            case (r_state)
                ST_IDLE: begin
                    if (w_accept && (i_func == FUNC_TASK)) begin
                        r_duration <= i_duration;
                        r_time     <= w_t0;
                        r_inject   <= 1'b1;
                        r_state    <= ST_MIN;
                    end
                end
                ST_MIN: begin
                    if (w_tail.valid) begin
                        if (w_tail.min_free > r_time) begin
                            r_time <= w_tail.min_free;
                        end
                        r_inject <= 1'b1;
                        r_state  <= ST_PICK;
                    end
                end
                ST_PICK: begin
                    if (w_tail.valid) begin
                        r_done       <= 1'b1;
                        r_assigned   <= SLOT_W'(w_tail.best_idx);
                        r_start_out  <= r_time;
                        r_prev_start <= r_time;
                        r_arrival    <= w_arrival_next;
                        r_state      <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign busy              = (r_state != ST_IDLE);
    assign o_done            = r_done;
    assign o_assigned_server = r_assigned;
    assign o_start_second    = r_start_out;
    assign o_cfg_ready       = 1'b1;

endmodule

`default_nettype wire
